>>> hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hdl/upn_pkg.sv
// types and constants of the url percent normaliser
`default_nettype none
package upn_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // decoded bytes one transaction can hand to the re-encoder
    localparam int N_SLOT  = 3;
    // per slot a flush piece and a main piece, then final flush, pass-through, terminator
    localparam int N_PIECE = 2 * N_SLOT + 3;
    localparam int PW      = $clog2(N_PIECE);
    localparam int N_PAIR  = N_SLOT + 1;
    localparam int PAW     = $clog2(N_PAIR);

    localparam int P_FLUSH_END = 2 * N_SLOT;
    localparam int P_LIT       = 2 * N_SLOT + 1;
    localparam int P_TERM      = 2 * N_SLOT + 2;

    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        PC_NONE,
        PC_ENC,
        PC_PCT3,
        PC_FL1,
        PC_FL2,
        PC_LIT,
        PC_TERM
    } t_piece;

    typedef struct packed {
        t_piece [N_PIECE-1:0]      kind;
        logic   [N_PAIR-1:0][7:0]  hb;
        logic   [N_PAIR-1:0][7:0]  db;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

>>> hdl/upn_in_if.sv
// input byte channel
`default_nettype none
interface upn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

>>> hdl/upn_out_if.sv
// normalised output byte channel
`default_nettype none
interface upn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/upn_front.sv
// front end: escape decoding, segment tracking and piece classification
`default_nettype none
`include "assert_macros.svh"
module upn_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    upn_in_if.sink              i_in,
    input  upn_pkg::t_q_status  i_q_stat,
    output logic                o_push,
    output upn_pkg::t_bundle    o_bundle
);
    import upn_pkg::*;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        return c[3:0] + (c[6] ? 4'd9 : 4'd0);
    endfunction

    function automatic logic is_reserved(input logic [7:0] c);
        return c inside {"-", "_", ".", "!", "~", "*", "'", "(", ")", ";", "/", "?",
                         ":", "@", "&", "=", "+", "$", ","};
    endfunction

    function automatic t_piece flush_kind(input logic [1:0] dc);
        t_piece k;
        case (dc)
            2'd1:    k = PC_FL1;
            2'd2:    k = PC_FL2;
            default: k = PC_NONE;
        endcase
        return k;
    endfunction

    logic [1:0] r_wc, n_wc;
    logic [7:0] r_w1, n_w1;
    logic       r_drop, n_drop;
    logic [1:0] r_dc, n_dc;
    logic [7:0] r_h1, n_h1;

    logic       take;
    logic [7:0] c;
    logic       last;
    logic       res;
    logic       fl_end;

    logic [4:0]                  cv;
    logic [4:0][7:0]             cb;
    logic [N_SLOT-1:0]           dv;
    logic [N_SLOT-1:0][7:0]      dd;
    logic [1:0]                  dn;

    logic [1:0] s_dc;
    logic [7:0] s_h;
    logic       s_drop_ev;
    logic       has_piece;

    assign i_in.ready = i_rst_n && !i_q_stat.full;
    assign take       = i_in.valid && i_in.ready;
    assign c          = i_in.in_byte;
    assign last       = i_in.in_last;
    assign res        = is_reserved(c);

    // raw layer: candidate decoded bytes in order, window flush, main byte, end flush
    always_comb begin
        n_wc   = r_wc;
        n_w1   = r_w1;
        fl_end = 1'b0;
        cv     = '0;
        cb[0]  = CH_PCT;
        cb[1]  = r_w1;
        cb[2]  = c;
        cb[3]  = CH_PCT;
        if (res) begin
            cv[0]  = r_wc != 2'd0;
            cv[1]  = r_wc == 2'd2;
            n_wc   = 2'd0;
            fl_end = 1'b1;
        end else if (!r_drop) begin
            if (r_wc != 2'd0 && is_hex(c)) begin
                if (r_wc == 2'd1) begin
                    n_wc = 2'd2;
                    n_w1 = c;
                end else begin
                    cv[2] = 1'b1;
                    cb[2] = {hex_value(r_w1), hex_value(c)};
                    n_wc  = 2'd0;
                end
            end else begin
                cv[0] = r_wc != 2'd0;
                cv[1] = r_wc == 2'd2;
                if (c == CH_PCT) begin
                    n_wc = 2'd1;
                end else begin
                    n_wc  = 2'd0;
                    cv[2] = 1'b1;
                end
            end
            if (last) begin
                cv[3]  = n_wc != 2'd0;
                cv[4]  = n_wc == 2'd2;
                n_wc   = 2'd0;
                fl_end = 1'b1;
            end
        end else begin
            fl_end = last;
        end
        cb[4] = n_w1;
    end

    // pack the candidates into the decoded slots
    always_comb begin
        dv = '0;
        dd = '0;
        dn = 2'd0;
        for (int i = 0; i < 5; i++) begin
            if (cv[i]) begin
                dv[dn] = 1'b1;
                dd[dn] = cb[i];
                dn     = dn + 2'd1;
            end
        end
    end

    // decoded layer: held decoded percent and digit, pieces for the back end
    always_comb begin
        s_dc      = r_dc;
        s_h       = r_h1;
        s_drop_ev = 1'b0;
        o_bundle  = '0;
        for (int i = 0; i < N_SLOT; i++) begin
            o_bundle.hb[i] = s_h;
            o_bundle.db[i] = dd[i];
            if (dv[i]) begin
                if (dd[i] == CH_NUL) begin
                    o_bundle.kind[2*i] = flush_kind(s_dc);
                    s_dc      = 2'd0;
                    s_drop_ev = 1'b1;
                end else if (s_dc != 2'd0 && is_hex(dd[i])) begin
                    if (s_dc == 2'd1) begin
                        s_h  = dd[i];
                        s_dc = 2'd2;
                    end else begin
                        o_bundle.kind[2*i+1] = PC_PCT3;
                        s_dc = 2'd0;
                    end
                end else begin
                    o_bundle.kind[2*i] = flush_kind(s_dc);
                    if (dd[i] == CH_PCT) begin
                        s_dc = 2'd1;
                    end else begin
                        o_bundle.kind[2*i+1] = PC_ENC;
                        s_dc = 2'd0;
                    end
                end
            end
        end
        o_bundle.hb[N_PAIR-1] = s_h;
        o_bundle.db[N_PAIR-1] = c;
        if (fl_end) begin
            o_bundle.kind[P_FLUSH_END] = flush_kind(s_dc);
            s_dc = 2'd0;
        end
        if (res) begin
            o_bundle.kind[P_LIT] = PC_LIT;
        end
        if (last) begin
            o_bundle.kind[P_TERM] = PC_TERM;
        end
        n_dc   = s_dc;
        n_h1   = s_h;
        n_drop = (r_drop || s_drop_ev) && !fl_end;
    end

    always_comb begin
        has_piece = 1'b0;
        for (int j = 0; j < N_PIECE; j++) begin
            if (o_bundle.kind[j] != PC_NONE) begin
                has_piece = 1'b1;
            end
        end
    end

    assign o_push = take && has_piece;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc   <= 2'd0;
            r_drop <= 1'b0;
            r_dc   <= 2'd0;
        end else if (take) begin
            r_wc   <= n_wc;
            r_drop <= n_drop;
            r_dc   <= n_dc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_w1 <= n_w1;
            r_h1 <= n_h1;
        end
    end

    `ASSERT_NEXT(a_string_end_clears, i_clk, i_rst_n, take && last, r_wc == 2'd0 && r_dc == 2'd0 && !r_drop, "state not cleared after final byte")
    `ASSERT_IMPL(a_drop_holds_empty, i_clk, i_rst_n, r_drop, r_wc == 2'd0 && r_dc == 2'd0, "held bytes while segment dropped")

endmodule
`default_nettype wire

>>> hdl/upn_queue.sv
// short bundle queue between front and back end
`default_nettype none
`include "assert_macros.svh"
module upn_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  upn_pkg::t_bundle    i_bundle,
    input  wire logic           i_pop,
    output upn_pkg::t_bundle    o_head,
    output upn_pkg::t_q_status  o_stat
);
    import upn_pkg::*;

    t_bundle         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_cnt, n_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == Q_CW'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign n_cnt        = r_cnt + Q_CW'(i_push) - Q_CW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_bundle;
        end
    end

    `ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_stat.empty, "pop from empty queue")
    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_stat.full, "push into full queue")

endmodule
`default_nettype wire

>>> hdl/upn_back.sv
// back end: expands pieces into output bytes, one per cycle while the receiver is ready
`default_nettype none
`include "assert_macros.svh"
module upn_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  upn_pkg::t_bundle    i_head,
    input  upn_pkg::t_q_status  i_q_stat,
    output logic                o_pop,
    upn_out_if.source           o_out
);
    import upn_pkg::*;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h37 + 8'(v));
    endfunction

    function automatic logic [1:0] piece_lastk(input t_piece k, input logic [7:0] d);
        logic [1:0] n;
        case (k)
            PC_ENC:          n = is_alnum(d) ? 2'd0 : 2'd2;
            PC_PCT3, PC_FL1: n = 2'd2;
            PC_FL2:          n = 2'd3;
            default:         n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] piece_byte(input t_piece k, input logic [7:0] h,
                                              input logic [7:0] d, input logic [1:0] idx);
        logic [7:0] b;
        b = CH_NUL;
        case (k)
            PC_ENC: begin
                if (is_alnum(d)) begin
                    b = d;
                end else begin
                    case (idx)
                        2'd0:    b = CH_PCT;
                        2'd1:    b = hex_digit(d[7:4]);
                        default: b = hex_digit(d[3:0]);
                    endcase
                end
            end
            PC_PCT3: begin
                case (idx)
                    2'd0:    b = CH_PCT;
                    2'd1:    b = h;
                    default: b = d;
                endcase
            end
            PC_FL1, PC_FL2: begin
                // a lone percent comes out as %25, a held digit after it as itself
                case (idx)
                    2'd0:    b = CH_PCT;
                    2'd1:    b = hex_digit(CH_PCT[7:4]);
                    2'd2:    b = hex_digit(CH_PCT[3:0]);
                    default: b = h;
                endcase
            end
            PC_LIT:  b = d;
            default: b = CH_NUL;
        endcase
        return b;
    endfunction

    logic [PW-1:0]  r_p, n_p;
    logic [1:0]     r_k, n_k;
    logic           r_ov, n_ov;
    logic [7:0]     r_ob, n_ob;
    logic           r_ol, n_ol;
    logic           r_oe, n_oe;

    logic [N_PIECE-1:0] ne;
    logic [PW-1:0]      cur;
    logic               more;
    logic [PAW-1:0]     pi;
    t_piece             kind_c;
    logic [7:0]         hb, db;
    logic [1:0]         lastk;
    logic [7:0]         byte_c;
    logic               adv;
    logic               end_piece;
    logic               done;

    always_comb begin
        cur  = '0;
        more = 1'b0;
        for (int j = 0; j < N_PIECE; j++) begin
            ne[j] = i_head.kind[j] != PC_NONE;
        end
        // lowest filled piece at or after the current position
        for (int j = N_PIECE - 1; j >= 0; j--) begin
            if (ne[j] && PW'(j) >= r_p) begin
                cur = PW'(j);
            end
        end
        for (int j = 0; j < N_PIECE; j++) begin
            if (ne[j] && PW'(j) > cur) begin
                more = 1'b1;
            end
        end
    end

    assign pi        = (cur < PW'(P_FLUSH_END)) ? PAW'(cur >> 1) : PAW'(N_PAIR - 1);
    assign kind_c    = i_head.kind[cur];
    assign hb        = i_head.hb[pi];
    assign db        = i_head.db[pi];
    assign lastk     = piece_lastk(kind_c, db);
    assign byte_c    = piece_byte(kind_c, hb, db, r_k);
    assign adv       = !i_q_stat.empty && (!r_ov || o_out.ready);
    assign end_piece = r_k == lastk;
    assign done      = end_piece && !more;
    assign o_pop     = adv && done;

    always_comb begin
        n_p  = r_p;
        n_k  = r_k;
        n_ov = r_ov;
        n_ob = r_ob;
        n_ol = r_ol;
        n_oe = r_oe;
        if (adv) begin
            n_ov = 1'b1;
            n_ob = byte_c;
            n_ol = done;
            n_oe = kind_c == PC_TERM;
            if (end_piece) begin
                n_k = 2'd0;
                n_p = done ? '0 : cur + 1'b1;
            end else begin
                n_k = r_k + 2'd1;
            end
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p  <= '0;
            r_k  <= 2'd0;
            r_ov <= 1'b0;
        end else begin
            r_p  <= n_p;
            r_k  <= n_k;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob <= n_ob;
        r_ol <= n_ol;
        r_oe <= n_oe;
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.run_last   = r_ol;
    assign o_out.string_end = r_oe;

    `ASSERT_IMPL(a_term_closes_run, i_clk, i_rst_n, r_ov && r_oe, r_ol && r_ob == CH_NUL, "terminator not last or not zero")
    `ASSERT_IMPL(a_mid_piece_has_head, i_clk, i_rst_n, r_k != 2'd0, !i_q_stat.empty, "piece in progress without queue head")

endmodule
`default_nettype wire

>>> hdl/url_percent_normalizer.sv
// top level of the url percent normaliser
//
// i_in carries one url byte per transaction with in_last on the final byte of a
// string. o_out carries the normalised bytes; run_last marks the last byte that
// an input byte produced, string_end the zero terminator after the final byte.
// An input byte yields from zero to twelve output bytes: reserved characters
// pass through, escapes are decoded and everything is re-encoded as %HH except
// alphanumerics and existing %XX sequences.
// The front end takes one input transaction per cycle while its four-entry
// queue has room and turns it into a bundle of pieces. The back end empties the
// queue at one output byte per cycle while the receiver is ready; an input
// yields three for an encoded byte, one for a kept byte, and bytes that are
// only held, such as the digits of an escape, yield none. The bytes of a
// result pass through the queue and the output register before o_out.
// When the receiver stalls, the output register holds its byte, the queue
// fills and i_in.ready drops once it is full.
// Reset is synchronous: it empties the queue and output register and clears
// all escape and segment state; i_in.ready stays low while reset is asserted.
`default_nettype none
module url_percent_normalizer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    upn_in_if.sink      i_in,
    upn_out_if.source   o_out
);
    import upn_pkg::*;

    logic       push;
    logic       pop;
    t_bundle    bundle;
    t_bundle    head;
    t_q_status  q_stat;

    upn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_bundle (bundle)
    );

    upn_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (q_stat)
    );

    upn_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire

>>> verif/upn_norm_checker.sv
// checker for the url percent normaliser: watches both channels, predicts and compares
module upn_norm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    upn_in_if    i_in_ch,
    upn_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_accepted,
    output int   o_pending,
    output int   o_checked
);
    import upn_pkg::*;

    localparam int MAX_PER_ITEM = 12;

    typedef struct packed {
        logic [7:0] b;
        logic       run_last;
        logic       string_end;
    } t_norm_byte;

    // raw escape window: a '%' and up to one hex digit
    logic [1:0] raw_cnt;
    logic [7:0] raw_second;
    logic       seg_drop;
    // decoded window: a decoded '%' waiting for two hex characters
    logic [1:0] dec_cnt;
    logic [7:0] dec_second;

    t_norm_byte item_bytes[$];
    t_norm_byte expected_bytes[$];
    t_norm_byte want;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_mark(input logic [7:0] c);
        case (c)
            "-", "_", ".", "!", "~", "*", "'", "(", ")", ";", "/", "?", ":", "@",
            "&", "=", "+", "$", ",": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c >= "0" && c <= "9") t = c - "0";
        else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
        else t = c - ("A" - 8'd10);
        return t[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? ("0" + {4'h0, v}) : ("A" - 8'd10 + {4'h0, v});
    endfunction

    function automatic void put_byte(input logic [7:0] b, input logic term);
        t_norm_byte r;
        if (item_bytes.size() < MAX_PER_ITEM) begin
            r.b = b;
            r.run_last = 1'b0;
            r.string_end = term;
            item_bytes.push_back(r);
        end
    endfunction

    function automatic void encode_out(input logic [7:0] c);
        if (is_alnum(c)) begin
            put_byte(c, 1'b0);
        end else begin
            put_byte(CH_PCT, 1'b0);
            put_byte(hex_char(c[7:4]), 1'b0);
            put_byte(hex_char(c[3:0]), 1'b0);
        end
    endfunction

    function automatic void flush_dec();
        logic [1:0] n;
        n = dec_cnt;
        dec_cnt = 2'd0;
        if (n >= 2'd1) encode_out(CH_PCT);
        if (n >= 2'd2) encode_out(dec_second);
    endfunction

    function automatic void push_dec(input logic [7:0] d);
        if (dec_cnt != 2'd0) begin
            if (is_hex(d)) begin
                if (dec_cnt == 2'd1) begin
                    dec_second = d;
                    dec_cnt = 2'd2;
                end else begin
                    // an existing %XX sequence is kept as it stands
                    dec_cnt = 2'd0;
                    put_byte(CH_PCT, 1'b0);
                    put_byte(dec_second, 1'b0);
                    put_byte(d, 1'b0);
                end
                return;
            end
            flush_dec();
        end
        if (d == CH_PCT) dec_cnt = 2'd1;
        else encode_out(d);
    endfunction

    function automatic void take_decoded(input logic [7:0] d);
        if (d == CH_NUL) begin
            flush_dec();
            seg_drop = 1'b1;
            raw_cnt = 2'd0;
        end else begin
            push_dec(d);
        end
    endfunction

    function automatic void flush_raw();
        logic [1:0] n;
        logic [7:0] second;
        n = raw_cnt;
        second = raw_second;
        raw_cnt = 2'd0;
        if (n >= 2'd1) take_decoded(CH_PCT);
        if (n >= 2'd2) take_decoded(second);
    endfunction

    function automatic void push_raw(input logic [7:0] c);
        if (seg_drop) return;
        if (raw_cnt != 2'd0) begin
            if (is_hex(c)) begin
                if (raw_cnt == 2'd1) begin
                    raw_second = c;
                    raw_cnt = 2'd2;
                end else begin
                    raw_cnt = 2'd0;
                    take_decoded({hex_val(raw_second), hex_val(c)});
                end
                return;
            end
            flush_raw();
            if (seg_drop) return;
        end
        if (c == CH_PCT) raw_cnt = 2'd1;
        else take_decoded(c);
    endfunction

    function automatic void close_segment();
        flush_raw();
        flush_dec();
        raw_cnt = 2'd0;
        seg_drop = 1'b0;
    endfunction

    function automatic void normalise_byte(input logic [7:0] c, input logic last);
        item_bytes.delete();
        if (is_mark(c)) begin
            close_segment();
            put_byte(c, 1'b0);
        end else begin
            push_raw(c);
        end
        if (last) begin
            close_segment();
            put_byte(CH_NUL, 1'b1);
        end
        if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].run_last = 1'b1;
        foreach (item_bytes[k]) expected_bytes.push_back(item_bytes[k]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            raw_cnt = 2'd0;
            raw_second = 8'h00;
            seg_drop = 1'b0;
            dec_cnt = 2'd0;
            dec_second = 8'h00;
            expected_bytes.delete();
            o_fail_count = 0;
            o_accepted = 0;
            o_checked = 0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                normalise_byte(i_in_ch.in_byte, i_in_ch.in_last);
                o_accepted++;
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected nothing, got %02h", i_out_ch.out_byte);
                    o_fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    o_checked++;
                    if (i_out_ch.out_byte !== want.b) begin
                        $error("out_byte: expected %02h, got %02h", want.b,
                               i_out_ch.out_byte);
                        o_fail_count++;
                    end
                    if (i_out_ch.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last,
                               i_out_ch.run_last);
                        o_fail_count++;
                    end
                    if (i_out_ch.string_end !== want.string_end) begin
                        $error("string_end: expected %0b, got %0b", want.string_end,
                               i_out_ch.string_end);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

>>> verif/testbench.sv
// stimulus and verdict for the url percent normaliser
module testbench;
    import upn_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 130;
    localparam int TAIL_CYCLES  = 16;

    localparam string MARK_CHARS    = "-_.!~*'();/?:@&=+$,";
    localparam string NON_HEX_CHARS = "GgZz/.x~ q";

    logic i_clk;
    logic i_rst_n;

    upn_in_if  in_ch();
    upn_out_if out_ch();

    int n_fail;
    int n_accepted;
    int n_pending;
    int n_checked;

    int n_sent;
    int n_strings;
    int burst_left;
    int cycle_cnt  = 0;
    int stall_left = 0;
    int stall_mode = 0;

    logic [7:0] url_bytes[$];

    url_percent_normalizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    upn_norm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (n_fail),
        .o_accepted   (n_accepted),
        .o_pending    (n_pending),
        .o_checked    (n_checked)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: stretches of always ready, random, heavy and periodic stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= (cycle_cnt % 5) != 0;
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        n_sent++;
        if (last) n_strings++;
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_hex_char(input logic [3:0] v);
        if (v < 4'd10) return "0" + {4'h0, v};
        return ($urandom_range(0, 1) ? "a" : "A") - 8'd10 + {4'h0, v};
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [6:0] hi;
        hi = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 1)) return NON_HEX_CHARS[$urandom_range(0, NON_HEX_CHARS.len() - 1)];
        return {1'b1, hi};
    endfunction

    function automatic void add_token();
        int kind;
        int r;
        logic [7:0] v;
        kind = $urandom_range(0, 9);
        r = $urandom_range(0, 61);
        v = 8'($urandom_range(0, 255));
        case (kind)
            0, 1, 2: begin
                if (r < 10) url_bytes.push_back("0" + 8'(r));
                else if (r < 36) url_bytes.push_back("A" + 8'(r - 10));
                else url_bytes.push_back("a" + 8'(r - 36));
            end
            3: url_bytes.push_back(MARK_CHARS[$urandom_range(0, MARK_CHARS.len() - 1)]);
            4, 5: begin
                // decodable escape, often of a zero or a percent sign
                case ($urandom_range(0, 3))
                    0:       v = CH_NUL;
                    1:       v = CH_PCT;
                    default: ;
                endcase
                url_bytes.push_back(CH_PCT);
                url_bytes.push_back(rand_hex_char(v[7:4]));
                url_bytes.push_back(rand_hex_char(v[3:0]));
            end
            6: begin
                url_bytes.push_back(CH_PCT);
                if ($urandom_range(0, 1)) url_bytes.push_back(rand_hex_char(v[3:0]));
                if ($urandom_range(0, 2) != 0) url_bytes.push_back(rand_non_hex());
            end
            7: url_bytes.push_back(v);
            8: begin
                // escaped percent sign that may form a kept %XX with what follows
                url_bytes.push_back(CH_PCT);
                url_bytes.push_back("2");
                url_bytes.push_back("5");
                url_bytes.push_back(rand_hex_char(v[7:4]));
                if ($urandom_range(0, 1)) url_bytes.push_back(rand_hex_char(v[3:0]));
            end
            default: begin
                url_bytes.push_back(CH_PCT);
                url_bytes.push_back(rand_non_hex());
            end
        endcase
    endfunction

    initial begin
        int n_tokens;
        int k;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        burst_left    = 0;
        n_sent        = 0;
        n_strings     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: decode with lower-case digit, decoded percent kept as %41,
        // decoded zero dropping its segment, raw zero, percent before a non-hex
        // character, unfinished escape at string end, byte extremes
        send_text("a%4a/", 1'b0);
        send_text("%2541", 1'b0);
        send_text("%00B;", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_text("c,", 1'b0);
        send_text("%G%4", 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b1);

        k = n_sent;
        while (n_sent < k + RANDOM_ITEMS) begin
            url_bytes.delete();
            n_tokens = $urandom_range(1, 6);
            repeat (n_tokens) add_token();
            foreach (url_bytes[j]) send_byte(url_bytes[j], j == url_bytes.size() - 1);
        end
        in_ch.valid <= 1'b0;

        while (n_accepted != n_sent || n_pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d url strings, %0d input bytes, %0d normalised bytes checked",
                 n_strings, n_sent, n_checked);
        if (n_fail == 0 && n_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/upn_pkg.sv
hdl/upn_in_if.sv
hdl/upn_out_if.sv
hdl/upn_front.sv
hdl/upn_queue.sv
hdl/upn_back.sv
hdl/url_percent_normalizer.sv
verif/upn_norm_checker.sv
verif/testbench.sv
